[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every enabled edge
`define AST_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: always");

// consequent holds on the same edge as the antecedent
`define AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent holds on the edge after the antecedent
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/blr_pkg.sv]
// ---------------------------------------------------------------------------
// blr_pkg
// shared types and constants of the block linear resampler
// ---------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  typedef logic signed [15:0] sample_t;

  // outputs per block, a power of two so the phase splits into index and fraction
  localparam int FRAC_W        = 11;
  localparam int OUT_PER_BLOCK = 1 << FRAC_W;
  localparam int OUT_IDX_W     = FRAC_W + 1;

  localparam int RATE_W   = 13;
  localparam int ACC_W    = 24;
  localparam int RATE_MIN = 1024;
  localparam int RATE_MAX = 4096;
  localparam int RATE_RST = 2560;

  // register indexes
  localparam logic REG_IN_PER_MS = 1'b0;
  localparam logic REG_IQ_SWAP   = 1'b1;

endpackage

`default_nettype wire

[rtl/blr_interp.sv]
// ---------------------------------------------------------------------------
// blr_interp
// one-lane linear interpolation x0 + round((x1 - x0) * r / 2^FRAC_W)
// ---------------------------------------------------------------------------
`default_nettype none

module blr_interp (
  input  blr_pkg::sample_t            x0,
  input  blr_pkg::sample_t            x1,
  input  logic [blr_pkg::FRAC_W-1:0]  frac,
  output blr_pkg::sample_t            y
);
  import blr_pkg::*;

  localparam int PROD_W = 17 + FRAC_W + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(OUT_PER_BLOCK / 2);

  logic signed [16:0]              diff;
  logic signed [PROD_W-1:0]        prod;
  logic signed [PROD_W-1:0]        biased;
  logic signed [PROD_W-FRAC_W-1:0] step;
  logic signed [PROD_W-FRAC_W-1:0] sum;

  assign diff   = {x1[15], x1} - {x0[15], x0};
  assign prod   = diff * $signed({1'b0, frac});
  assign biased = prod + HALF;
  // floor division by a power of two: keep the upper bits
  assign step   = biased[PROD_W-1:FRAC_W];
  assign sum    = {{(PROD_W-FRAC_W-16){x0[15]}}, x0} + step;
  assign y      = sum[15:0];

endmodule

`default_nettype wire

[rtl/block_linear_resampler.sv]
// path: the first result of an input goes from the pending-job registers into the output register
// flow: an input is taken while no job is pending or while the pending job emits its last result;
//   the single output register takes one result per cycle while out_stall is low
// reset: synchronous active-low rst_n; in_per_ms returns to 2560, iq_swap to 0,
//   the first input after reset only primes the previous-sample store
// ---------------------------------------------------------------------------
// block_linear_resampler
// resamples I/Q input blocks to a fixed number of linearly interpolated outputs
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module block_linear_resampler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [blr_pkg::RATE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  blr_pkg::sample_t            in_sample_i,
  input  blr_pkg::sample_t            in_sample_q,
  output logic                        out_valid,
  input  logic                        out_stall,
  output blr_pkg::sample_t            out_i,
  output blr_pkg::sample_t            out_q,
  output logic                        out_last_in_run,
  output logic                        out_block_end
);
  import blr_pkg::*;

  localparam logic [RATE_W-1:0]    RMIN     = RATE_W'(RATE_MIN);
  localparam logic [RATE_W-1:0]    RMAX     = RATE_W'(RATE_MAX);
  localparam logic [OUT_IDX_W-1:0] IDX_LAST = OUT_IDX_W'(OUT_PER_BLOCK - 1);
  localparam logic [OUT_IDX_W-1:0] IDX_PREV = OUT_IDX_W'(OUT_PER_BLOCK - 2);

  // configuration
  logic [RATE_W-1:0] in_per_ms_r;
  logic              iq_swap_r;

  // block state
  sample_t              prev_i_r, prev_q_r;
  logic [RATE_W-1:0]    in_pos_r, in_pos_nxt;
  logic [OUT_IDX_W-1:0] out_index_r, out_index_nxt;
  logic [ACC_W-1:0]     phase_acc_r, phase_acc_nxt;

  // pending job: one input with its one or two results
  logic              job_valid_r, job_valid_nxt;
  logic              job_sel_r, job_sel_nxt;
  logic              job_two_r;
  sample_t           job_x0i_r, job_x0q_r, job_x1i_r, job_x1q_r;
  logic [FRAC_W-1:0] job_r0_r, job_r1_r;
  logic              job_be0_r, job_be1_r;

  // output register
  logic    out_valid_r;
  sample_t out_i_r, out_q_r;
  logic    out_last_r, out_be_r;

  logic [RATE_W-1:0] rate;
  logic [ACC_W-1:0]  acc1, acc2;
  logic              due1, due2, block_wrap, in_xfer, new_job;
  logic              out_ld, emit, job_done;
  logic [FRAC_W-1:0] frac_sel;
  sample_t           yi, yq;

  always_comb begin
    if (in_per_ms_r < RMIN) begin
      rate = RMIN;
    end else if (in_per_ms_r > RMAX) begin
      rate = RMAX;
    end else begin
      rate = in_per_ms_r;
    end
  end

  assign acc1 = phase_acc_r + ACC_W'(rate);
  assign acc2 = phase_acc_r + ACC_W'({rate, 1'b0});

  assign due1 = !out_index_r[OUT_IDX_W-1] &&
                (RATE_W'(phase_acc_r[ACC_W-1:FRAC_W]) < in_pos_r);
  assign due2 = due1 && (out_index_r != IDX_LAST) &&
                (RATE_W'(acc1[ACC_W-1:FRAC_W]) < in_pos_r);
  assign block_wrap = (in_pos_r >= rate);

  // handshake
  assign out_ld   = !out_valid_r || !out_stall;
  assign emit     = job_valid_r && out_ld;
  assign job_done = emit && (job_sel_r || !job_two_r);
  assign in_stall = job_valid_r && !job_done;
  assign in_xfer  = in_valid && !in_stall;
  assign new_job  = in_xfer && (in_pos_r != '0) && due1;

  always_comb begin
    in_pos_nxt    = in_pos_r;
    out_index_nxt = out_index_r;
    phase_acc_nxt = phase_acc_r;
    if (in_xfer) begin
      if (in_pos_r == '0 || block_wrap) begin
        in_pos_nxt    = RATE_W'(1);
        out_index_nxt = '0;
        phase_acc_nxt = '0;
      end else begin
        in_pos_nxt = in_pos_r + RATE_W'(1);
        if (due2) begin
          out_index_nxt = out_index_r + OUT_IDX_W'(2);
          phase_acc_nxt = acc2;
        end else if (due1) begin
          out_index_nxt = out_index_r + OUT_IDX_W'(1);
          phase_acc_nxt = acc1;
        end
      end
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_sel_nxt   = job_sel_r;
    if (new_job) begin
      job_valid_nxt = 1'b1;
      job_sel_nxt   = 1'b0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
      job_sel_nxt   = 1'b0;
    end else if (emit) begin
      job_sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_per_ms_r <= RATE_W'(RATE_RST);
      iq_swap_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_PER_MS: in_per_ms_r <= cfg_data;
        REG_IQ_SWAP:   iq_swap_r   <= cfg_data[0];
        default:       in_per_ms_r <= in_per_ms_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r    <= '0;
      out_index_r <= '0;
      phase_acc_r <= '0;
      job_valid_r <= 1'b0;
      job_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_pos_r    <= in_pos_nxt;
      out_index_r <= out_index_nxt;
      phase_acc_r <= phase_acc_nxt;
      job_valid_r <= job_valid_nxt;
      job_sel_r   <= job_sel_nxt;
      if (out_ld) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prev_i_r <= in_sample_i;
      prev_q_r <= in_sample_q;
    end
    if (new_job) begin
      job_two_r <= due2;
      job_x0i_r <= prev_i_r;
      job_x0q_r <= prev_q_r;
      job_x1i_r <= in_sample_i;
      job_x1q_r <= in_sample_q;
      job_r0_r  <= phase_acc_r[FRAC_W-1:0];
      job_r1_r  <= acc1[FRAC_W-1:0];
      job_be0_r <= (out_index_r == IDX_LAST);
      job_be1_r <= (out_index_r == IDX_PREV);
    end
    if (emit) begin
      out_i_r    <= iq_swap_r ? yq : yi;
      out_q_r    <= iq_swap_r ? yi : yq;
      out_last_r <= job_sel_r || !job_two_r;
      out_be_r   <= job_sel_r ? job_be1_r : job_be0_r;
    end
  end

  assign frac_sel = job_sel_r ? job_r1_r : job_r0_r;

  blr_interp u_interp_i (
    .x0   (job_x0i_r),
    .x1   (job_x1i_r),
    .frac (frac_sel),
    .y    (yi)
  );

  blr_interp u_interp_q (
    .x0   (job_x0q_r),
    .x1   (job_x1q_r),
    .frac (frac_sel),
    .y    (yq)
  );

  assign out_valid       = out_valid_r;
  assign out_i           = out_i_r;
  assign out_q           = out_q_r;
  assign out_last_in_run = out_last_r;
  assign out_block_end   = out_be_r;

  `AST_ALWAYS(a_idx_range, out_index_r <= OUT_IDX_W'(OUT_PER_BLOCK))
  `AST_SAME(a_second_sel, job_valid_r && job_sel_r, job_two_r)
  `AST_NEXT(a_run_cont, out_valid && !out_stall && !out_last_in_run, out_valid)
  `AST_SAME(a_priming, in_pos_r == '0, (out_index_r == '0) && (phase_acc_r == '0))

endmodule

`default_nettype wire
